>>> hw/rtl/taf_pkg.sv
// ----------------------------------------------------------------------------
// taf_pkg
// Shared types, widths and codes of the two-class age-ordered FIFO unit.
// ----------------------------------------------------------------------------
package taf_pkg;

    // Storage configuration.
    localparam int QUEUE_DEPTH  = 16;
    localparam int TAG_BITS     = 16;
    localparam int STAMP_BITS   = 16;

    localparam int ADDR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_SUM_BITS = $clog2(2 * QUEUE_DEPTH);
    localparam int ENTRY_BITS   = TAG_BITS + STAMP_BITS;

    // Fixed port field widths.
    localparam int ACTION_BITS  = 2;
    localparam int STATUS_BITS  = 2;
    localparam int IN_TAG_BITS  = 16;
    localparam int OUT_TAG_BITS = 16;

    // Request actions.
    localparam logic [ACTION_BITS-1:0] ACT_ENQ  = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_ANY  = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_DEQ0 = 2'd2;
    localparam logic [ACTION_BITS-1:0] ACT_DEQ1 = 2'd3;

    // Response status codes.
    localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd2;

    // One stored item: its tag and its arrival stamp.
    typedef struct packed {
        logic [TAG_BITS-1:0]   tag;
        logic [STAMP_BITS-1:0] stamp;
    } entry_t;

    // Commands to one queue's pointer block.
    typedef struct packed {
        logic push;
        logic pop;
    } ptr_cmd_t;

    // State reported by one queue's pointer block.
    typedef struct packed {
        logic [ADDR_BITS-1:0]  head;
        logic [ADDR_BITS-1:0]  tail;
        logic [COUNT_BITS-1:0] count;
        logic                  empty;
        logic                  full;
    } ptr_stat_t;

endpackage

>>> hw/rtl/taf_channels.sv
// ----------------------------------------------------------------------------
// taf_channels
// Valid/ready channel interfaces for the request and response beats.
// ----------------------------------------------------------------------------
interface taf_req_if;
    import taf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ACTION_BITS-1:0] action;
    logic                   item_class;
    logic [IN_TAG_BITS-1:0] item_tag;

    modport source (output valid, output action, output item_class, output item_tag,
                    input ready);
    modport sink   (input valid, input action, input item_class, input item_tag,
                    output ready);
endinterface

interface taf_rsp_if;
    import taf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_BITS-1:0]  status;
    logic                    out_class;
    logic [OUT_TAG_BITS-1:0] out_tag;

    modport source (output valid, output status, output out_class, output out_tag,
                    input ready);
    modport sink   (input valid, input status, input out_class, input out_tag,
                    output ready);
endinterface

>>> hw/rtl/taf_ram.sv
// ----------------------------------------------------------------------------
// taf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module taf_ram #(
    parameter int DATA_BITS = 32,
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/taf_queue_ptr.sv
// ----------------------------------------------------------------------------
// taf_queue_ptr
// Head index and fill count of one circular queue, with derived tail index.
// ----------------------------------------------------------------------------
module taf_queue_ptr (
    input  logic                clk,
    input  logic                rst_n,
    input  taf_pkg::ptr_cmd_t   cmd,
    output taf_pkg::ptr_stat_t  stat
);
    import taf_pkg::*;

    logic [ADDR_BITS-1:0]    head_reg;
    logic [ADDR_BITS-1:0]    head_next;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   count_next;
    logic [PTR_SUM_BITS-1:0] tail_sum;
    logic [PTR_SUM_BITS-1:0] tail_wrap;

    // The tail sits count entries past the head, wrapped once at most.
    assign tail_sum  = PTR_SUM_BITS'(head_reg) + PTR_SUM_BITS'(count_reg);
    assign tail_wrap = (tail_sum >= PTR_SUM_BITS'(QUEUE_DEPTH))
                     ? tail_sum - PTR_SUM_BITS'(QUEUE_DEPTH) : tail_sum;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.pop)
        begin
            head_next = (head_reg == ADDR_BITS'(QUEUE_DEPTH - 1))
                      ? '0 : head_reg + ADDR_BITS'(1);
        end
        if (cmd.push && !cmd.pop)
        begin
            count_next = count_reg + COUNT_BITS'(1);
        end
        else if (cmd.pop && !cmd.push)
        begin
            count_next = count_reg - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign stat.head  = head_reg;
    assign stat.tail  = tail_wrap[ADDR_BITS-1:0];
    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == COUNT_BITS'(QUEUE_DEPTH));

endmodule

>>> hw/rtl/two_class_age_ordered_fifo_unit.sv
// ----------------------------------------------------------------------------
// two_class_age_ordered_fifo_unit
// Two class FIFOs held in synchronous RAMs, ordered by a global arrival stamp.
// ----------------------------------------------------------------------------
// Sequencing: an enqueue beat loads the response register at the accepting
// edge; a dequeue beat reads both RAM heads (registered read data), then
// loads it from the read state. Throughput: one enqueue per cycle while the
// response is ready; a dequeue blocks new requests until it leaves ST_READ.
// Reset: rst_n clears head indexes, fill counts, the arrival counter and the
// response valid; RAM contents are not reset; an empty head read is ignored.
// ----------------------------------------------------------------------------
module two_class_age_ordered_fifo_unit (
    input  logic        clk,
    input  logic        rst_n,
    taf_req_if.sink     req,
    taf_rsp_if.source   rsp
);
    import taf_pkg::*;

    // Control states: idle takes requests, read waits for the RAM heads.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                    state_reg;
    logic                    state_next;
    logic [ACTION_BITS-1:0]  act_reg;
    logic [STAMP_BITS-1:0]   stamp_reg;
    logic [STAMP_BITS-1:0]   stamp_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [STATUS_BITS-1:0]  out_status_reg;
    logic [STATUS_BITS-1:0]  out_status_next;
    logic                    out_class_reg;
    logic                    out_class_next;
    logic [OUT_TAG_BITS-1:0] out_tag_reg;
    logic [OUT_TAG_BITS-1:0] out_tag_next;

    logic                    accept;
    logic                    out_free;
    logic                    is_enq;
    logic                    enq_full;
    logic                    commit;
    logic                    rd_en;

    ptr_cmd_t                cmd0;
    ptr_cmd_t                cmd1;
    ptr_stat_t               stat0;
    ptr_stat_t               stat1;

    entry_t                  wr_entry;
    entry_t                  rd_entry0;
    entry_t                  rd_entry1;
    entry_t                  pick_entry;
    logic [STAMP_BITS-1:0]   stamp_diff;
    logic                    older0;
    logic                    pick_cls;
    logic                    pick_empty;

    // ------------------------------------------------------------------------
    // Handshake. A request is taken only in the idle state and only when the
    // response register is free or is being drained in the same cycle, so an
    // enqueue response can always be loaded at the accepting edge and a
    // dequeue response finds the register free in the read state.
    // ------------------------------------------------------------------------
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign is_enq    = (req.action == ACT_ENQ);
    assign enq_full  = req.item_class ? stat1.full : stat0.full;

    // ------------------------------------------------------------------------
    // Enqueue path. The item is written at the tail of its class queue in the
    // accepting cycle together with the current arrival stamp. A full queue
    // refuses the item and the stamp does not advance.
    // ------------------------------------------------------------------------
    assign wr_entry.tag   = TAG_BITS'(req.item_tag);
    assign wr_entry.stamp = stamp_reg;

    assign cmd0.push = accept && is_enq && !req.item_class && !stat0.full;
    assign cmd1.push = accept && is_enq &&  req.item_class && !stat1.full;

    assign stamp_next = (cmd0.push || cmd1.push) ? stamp_reg + STAMP_BITS'(1) : stamp_reg;

    // ------------------------------------------------------------------------
    // Dequeue path. Both head entries are read at the accepting edge; in the
    // read state their stamps are compared and one queue may be popped.
    // Writes happen only at enqueue acceptance, which never overlaps a
    // pending read, so no forwarding is needed.
    // ------------------------------------------------------------------------
    assign rd_en  = accept && !is_enq;
    assign commit = (state_reg == ST_READ) && out_free;

    // Wrap-aware age test: class 0 is older when the stamp difference is
    // negative; equal stamps go to class 1.
    assign stamp_diff = rd_entry0.stamp - rd_entry1.stamp;
    assign older0     = stamp_diff[STAMP_BITS-1];

    always_comb
    begin
        unique case (act_reg)
            ACT_DEQ0: pick_cls = 1'b0;
            ACT_DEQ1: pick_cls = 1'b1;
            ACT_ANY:
            begin
                if (!stat0.empty && !stat1.empty)
                begin
                    pick_cls = !older0;
                end
                else
                begin
                    // Only one queue holds items, or none: with none, the
                    // response reports class 0 as empty.
                    pick_cls = stat0.empty && !stat1.empty;
                end
            end
            ACT_ENQ:  pick_cls = 1'b0;
        endcase
    end

    assign pick_empty = pick_cls ? stat1.empty : stat0.empty;
    assign pick_entry = pick_cls ? rd_entry1 : rd_entry0;

    assign cmd0.pop = commit && !pick_empty && !pick_cls;
    assign cmd1.pop = commit && !pick_empty &&  pick_cls;

    // ------------------------------------------------------------------------
    // State sequencing and response register.
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        if (accept && !is_enq)
        begin
            state_next = ST_READ;
        end
        else if (commit)
        begin
            state_next = ST_IDLE;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_class_next  = out_class_reg;
        out_tag_next    = out_tag_reg;
        if (accept && is_enq)
        begin
            out_valid_next  = 1'b1;
            out_status_next = enq_full ? STAT_FULL : STAT_OK;
            out_class_next  = req.item_class;
            out_tag_next    = '0;
        end
        else if (commit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = pick_empty ? STAT_EMPTY : STAT_OK;
            out_class_next  = pick_cls;
            out_tag_next    = pick_empty ? '0 : OUT_TAG_BITS'(pick_entry.tag);
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stamp_reg     <= '0;
            out_valid_reg <= 1'b0;
            act_reg       <= ACT_ENQ;
        end
        else
        begin
            state_reg     <= state_next;
            stamp_reg     <= stamp_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                act_reg <= req.action;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_class_reg  <= out_class_next;
        out_tag_reg    <= out_tag_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.out_class = out_class_reg;
    assign rsp.out_tag   = out_tag_reg;

    // ------------------------------------------------------------------------
    // Queue pointers and storage.
    // ------------------------------------------------------------------------
    taf_queue_ptr u_ptr0 (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd0),
        .stat  (stat0)
    );

    taf_queue_ptr u_ptr1 (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd1),
        .stat  (stat1)
    );

    taf_ram #(
        .DATA_BITS (ENTRY_BITS),
        .DEPTH     (QUEUE_DEPTH)
    ) u_store0 (
        .clk     (clk),
        .wr_en   (cmd0.push),
        .wr_addr (stat0.tail),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (stat0.head),
        .rd_data (rd_entry0)
    );

    taf_ram #(
        .DATA_BITS (ENTRY_BITS),
        .DEPTH     (QUEUE_DEPTH)
    ) u_store1 (
        .clk     (clk),
        .wr_en   (cmd1.push),
        .wr_addr (stat1.tail),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (stat1.head),
        .rd_data (rd_entry1)
    );

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------

    // Fill counts never exceed the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stat0.count <= COUNT_BITS'(QUEUE_DEPTH)) && (stat1.count <= COUNT_BITS'(QUEUE_DEPTH)))
    else $error("queue fill count above depth");

    // An accepted dequeue completes in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_enq) |=> (state_reg == ST_READ) && commit)
    else $error("dequeue did not complete one cycle after acceptance");

    // Every accepted enqueue leaves the response register loaded with a zero tag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_enq) |=> out_valid_reg && (out_tag_reg == '0))
    else $error("enqueue response missing");

    // The arrival stamp advances only when an item is actually stored.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd0.push || cmd1.push) |=> $stable(stamp_reg))
    else $error("arrival stamp moved without a store");

endmodule
